[hw/rtl/kcl_pkg.sv]
// Shared definitions for the keypad combination lock: state codes, key codes,
// display modes and the step result bundle. No dependencies.
package kcl_pkg;

  localparam int KeyW   = 8;
  localparam int StateW = 4;
  localparam int LedW   = 3;
  localparam int ModeW  = 2;

  localparam logic [StateW-1:0] ST_LOCK   = 4'd0;
  localparam logic [StateW-1:0] ST_S1     = 4'd1;
  localparam logic [StateW-1:0] ST_S2     = 4'd2;
  localparam logic [StateW-1:0] ST_S3     = 4'd3;
  localparam logic [StateW-1:0] ST_UNLOCK = 4'd4;
  localparam logic [StateW-1:0] ST_W1     = 4'd5;
  localparam logic [StateW-1:0] ST_W2     = 4'd6;
  localparam logic [StateW-1:0] ST_W3     = 4'd7;
  localparam logic [StateW-1:0] ST_ALARM  = 4'd8;
  localparam logic [StateW-1:0] ST_A1     = 4'd9;
  localparam logic [StateW-1:0] ST_R1     = 4'd10;
  localparam logic [StateW-1:0] ST_R2     = 4'd11;
  localparam logic [StateW-1:0] ST_R3     = 4'd12;
  localparam logic [StateW-1:0] ST_RESET  = 4'd13;

  localparam logic [KeyW-1:0] KEY_ONE   = 8'h31;
  localparam logic [KeyW-1:0] KEY_TWO   = 8'h32;
  localparam logic [KeyW-1:0] KEY_THREE = 8'h33;

  localparam logic [ModeW-1:0] MODE_LEDS  = 2'd0;
  localparam logic [ModeW-1:0] MODE_FLASH = 2'd1;
  localparam logic [ModeW-1:0] MODE_ALARM = 2'd2;

  typedef struct packed {
    logic [StateW-1:0] state;
    logic [LedW-1:0]   leds;
    logic [ModeW-1:0]  mode;
  } step_t;

endpackage

[hw/rtl/keypad_combination_lock.sv]
// Top level of the keypad combination lock: input register, state registers
// and result register around kcl_step. Uses kcl_pkg.
//
// One key request in, one result out. A key is captured in an input register,
// and once the output register is free or draining it steps the lock state and
// LED registers through kcl_step while the result is written to the output
// register. Throughput is one key per cycle while results are taken. in_ready
// stays high while the output register is free or being drained, so one more
// key can wait in the input register while a result waits to be taken.
module keypad_combination_lock (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [kcl_pkg::KeyW-1:0]    key_code,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [kcl_pkg::StateW-1:0]  lock_state,
  output logic                        led_first,
  output logic                        led_second,
  output logic                        led_third,
  output logic [kcl_pkg::ModeW-1:0]   display_mode
);

  logic                        key_valid;
  logic [kcl_pkg::KeyW-1:0]    key;
  logic [kcl_pkg::StateW-1:0]  state;
  logic [kcl_pkg::LedW-1:0]    leds;
  kcl_pkg::step_t              step;
  kcl_pkg::step_t              result;
  logic                        advance;

  // key moves into the output register when that register is free or draining
  assign advance  = key_valid && (!out_valid || out_ready);
  assign in_ready = !key_valid || advance;

  kcl_step u_step (
    .state  (state),
    .leds   (leds),
    .key    (key),
    .result (step)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      key_valid <= 1'b0;
      out_valid <= 1'b0;
      state     <= kcl_pkg::ST_LOCK;
      leds      <= '0;
    end else begin
      if (in_ready) begin
        key_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= 1'b1;
        state     <= step.state;
        leds      <= step.leds;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      key <= key_code;
    end
    if (advance) begin
      result <= step;
    end
  end

  assign lock_state   = result.state;
  assign led_first    = result.leds[0];
  assign led_second   = result.leds[1];
  assign led_third    = result.leds[2];
  assign display_mode = result.mode;

endmodule

[hw/rtl/kcl_step.sv]
// Next-state, progress LED and display mode logic for one key request.
// Purely combinational; uses kcl_pkg.
module kcl_step (
  input  logic [kcl_pkg::StateW-1:0] state,
  input  logic [kcl_pkg::LedW-1:0]   leds,
  input  logic [kcl_pkg::KeyW-1:0]   key,
  output kcl_pkg::step_t             result
);

  logic k1, k2, k3;
  logic [kcl_pkg::StateW-1:0] state_next;
  logic [kcl_pkg::LedW-1:0]   leds_next;
  logic [kcl_pkg::ModeW-1:0]  mode;

  assign k1 = (key == kcl_pkg::KEY_ONE);
  assign k2 = (key == kcl_pkg::KEY_TWO);
  assign k3 = (key == kcl_pkg::KEY_THREE);

  always_comb begin
    case (state)
      kcl_pkg::ST_LOCK:   state_next = k2 ? kcl_pkg::ST_S1 :
                                       (k1 ? kcl_pkg::ST_R1 : kcl_pkg::ST_W1);
      kcl_pkg::ST_S1:     state_next = k3 ? kcl_pkg::ST_S2 :
                                       (k1 ? kcl_pkg::ST_R2 : kcl_pkg::ST_W2);
      kcl_pkg::ST_S2:     state_next = k1 ? kcl_pkg::ST_S3 : kcl_pkg::ST_W3;
      kcl_pkg::ST_S3:     state_next = k3 ? kcl_pkg::ST_UNLOCK :
                                       (k1 ? kcl_pkg::ST_RESET : kcl_pkg::ST_ALARM);
      kcl_pkg::ST_UNLOCK: state_next = kcl_pkg::ST_RESET;
      kcl_pkg::ST_W1:     state_next = k1 ? kcl_pkg::ST_R2 : kcl_pkg::ST_W2;
      kcl_pkg::ST_W2:     state_next = k1 ? kcl_pkg::ST_R3 : kcl_pkg::ST_W3;
      kcl_pkg::ST_W3:     state_next = kcl_pkg::ST_ALARM;
      kcl_pkg::ST_ALARM:  state_next = k3 ? kcl_pkg::ST_A1 : kcl_pkg::ST_ALARM;
      kcl_pkg::ST_A1:     state_next = k1 ? kcl_pkg::ST_RESET : kcl_pkg::ST_ALARM;
      kcl_pkg::ST_R1:     state_next = k1 ? kcl_pkg::ST_RESET : kcl_pkg::ST_W2;
      kcl_pkg::ST_R2:     state_next = k1 ? kcl_pkg::ST_RESET : kcl_pkg::ST_W3;
      kcl_pkg::ST_R3:     state_next = k1 ? kcl_pkg::ST_RESET : kcl_pkg::ST_W2;
      default:            state_next = kcl_pkg::ST_LOCK;  // reset and unused codes
    endcase
  end

  // LEDs latch on the stage just entered; entering reset clears them all
  always_comb begin
    case (state_next)
      kcl_pkg::ST_S1, kcl_pkg::ST_W1, kcl_pkg::ST_R1: leds_next = leds | 3'b001;
      kcl_pkg::ST_S2, kcl_pkg::ST_W2, kcl_pkg::ST_R2: leds_next = leds | 3'b010;
      kcl_pkg::ST_S3, kcl_pkg::ST_W3, kcl_pkg::ST_R3: leds_next = leds | 3'b100;
      kcl_pkg::ST_RESET:                              leds_next = '0;
      default:                                        leds_next = leds;
    endcase
  end

  always_comb begin
    case (state_next)
      kcl_pkg::ST_UNLOCK:                  mode = kcl_pkg::MODE_FLASH;
      kcl_pkg::ST_ALARM, kcl_pkg::ST_A1:   mode = kcl_pkg::MODE_ALARM;
      default:                             mode = kcl_pkg::MODE_LEDS;
    endcase
  end

  assign result.state = state_next;
  assign result.leds  = leds_next;
  assign result.mode  = mode;

endmodule

[hw/rtl/kcl_checker.sv]
// Port-level checks for keypad_combination_lock, attached with bind.
// Uses kcl_pkg.
module kcl_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [kcl_pkg::StateW-1:0]  lock_state,
  input logic                        led_first,
  input logic                        led_second,
  input logic                        led_third,
  input logic [kcl_pkg::ModeW-1:0]   display_mode
);

  // a stalled result holds its state and display mode
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(lock_state)
      && $stable(display_mode))
    else $error("stalled result changed");

  // the reset state always shows every LED off
  assert property (@(posedge clk) disable iff (rst)
    out_valid && lock_state == kcl_pkg::ST_RESET |->
      !led_first && !led_second && !led_third)
    else $error("LEDs lit in reset state");

  // display mode agrees with the state
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (display_mode == kcl_pkg::MODE_FLASH) ==
      (lock_state == kcl_pkg::ST_UNLOCK))
    else $error("flash mode mismatch");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (display_mode == kcl_pkg::MODE_ALARM) ==
      (lock_state == kcl_pkg::ST_ALARM || lock_state == kcl_pkg::ST_A1))
    else $error("alarm mode mismatch");

  // unused state codes are never reported
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> lock_state <= kcl_pkg::ST_RESET)
    else $error("unused state code");

endmodule

bind keypad_combination_lock kcl_checker u_kcl_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .lock_state   (lock_state),
  .led_first    (led_first),
  .led_second   (led_second),
  .led_third    (led_third),
  .display_mode (display_mode)
);
